[hdl/cire_pkg.sv]
// Shared types and constants for the square-root process Euler step block.
`default_nettype none
package cire_pkg;

  localparam int FRAC_BITS   = 24;
  localparam int SHIFT       = 2 * FRAC_BITS;
  localparam int ROOT_W      = 32;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int REM_W       = ROOT_W + 2;
  localparam int NUM_CELLS   = ROOT_W;
  localparam int PA_W        = 65;
  localparam int DRIFT_MAG_W = PA_W + 32;
  localparam int DIFFU_MAG_W = 96;
  localparam int DRIFT_W     = DRIFT_MAG_W + 1 - SHIFT;
  localparam int DIFFU_W     = DIFFU_MAG_W + 1 - SHIFT;
  localparam int SUM_W       = ((DRIFT_W > 33) ? DRIFT_W : 33) + 2;

  localparam logic [1:0] CFG_SPEED  = 2'd0;
  localparam logic [1:0] CFG_MEAN   = 2'd1;
  localparam logic [1:0] CFG_VOL    = 2'd2;
  localparam logic [1:0] CFG_SCHEME = 2'd3;

  localparam logic [1:0] SCH_PARTIAL = 2'd0;
  localparam logic [1:0] SCH_FULL    = 2'd1;
  localparam logic [1:0] SCH_REFLECT = 2'd2;
  localparam logic [1:0] SCH_SPARE   = 2'd3;

  typedef struct packed {
    logic signed [31:0] current_value;
    logic        [31:0] time_step;
    logic signed [31:0] normal_draw;
  } in_t;

  typedef struct packed {
    logic signed [31:0] next_value;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic [31:0] speed;
    logic [31:0] mean;
    logic [31:0] vol;
    logic [1:0]  scheme;
  } cfg_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
    logic [RAD_W-1:0]  rad;
    logic [PA_W-1:0]   pa;
    logic [31:0]       dt;
    logic signed [32:0] base;
    logic              diff_neg;
    logic [31:0]       dw_mag;
    logic              dw_neg;
  } cell_t;

endpackage
`default_nettype wire

[hdl/cire_front.sv]
// Front stages: scheme selection, drift difference and the radicand product.
`default_nettype none
module cire_front
  import cire_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire in_t   in_data,
  input  wire cfg_t  cfg,
  output logic       out_valid,
  output cell_t      out_cell
);

  logic               v1_r;
  logic signed [32:0] base_r;
  logic [32:0]        dmag_r;
  logic               dneg_r;
  logic [RAD_W-1:0]   sq_r;
  logic [31:0]        dt_r;
  logic [31:0]        dwm_r;
  logic               dwn_r;
  logic               v2_r;
  cell_t              cell_r;

  logic signed [32:0] x;
  logic signed [32:0] ax;
  logic signed [32:0] pos;
  logic signed [32:0] base;
  logic signed [32:0] d;
  logic signed [32:0] s;
  logic signed [33:0] diff;
  logic signed [32:0] dw;

  always_comb begin
    x   = 33'(in_data.current_value);
    ax  = x[32] ? -x : x;
    pos = x[32] ? 33'sd0 : x;
    case (cfg.scheme) inside
      SCH_REFLECT, SCH_SPARE: begin
        base = ax; d = ax; s = ax;
      end
      SCH_FULL: begin
        base = x; d = pos; s = pos;
      end
      default: begin
        base = x; d = x; s = pos;
      end
    endcase
    diff = $signed({2'b00, cfg.mean}) - 34'(d);
    dw   = 33'(in_data.normal_draw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_r <= base;
      dneg_r <= diff[33];
      dmag_r <= 33'(diff[33] ? -diff : diff);
      sq_r   <= s[31:0] * in_data.time_step;
      dt_r   <= in_data.time_step;
      dwn_r  <= dw[32];
      dwm_r  <= 32'(dw[32] ? -dw : dw);
      cell_r.root     <= '0;
      cell_r.rem      <= '0;
      cell_r.rad      <= sq_r;
      cell_r.pa       <= dmag_r * cfg.speed;
      cell_r.dt       <= dt_r;
      cell_r.base     <= base_r;
      cell_r.diff_neg <= dneg_r;
      cell_r.dw_mag   <= dwm_r;
      cell_r.dw_neg   <= dwn_r;
    end
  end

  assign out_valid = v2_r;
  assign out_cell  = cell_r;

endmodule
`default_nettype wire

[hdl/cire_root_cell.sv]
// One square-root cell: settles one root bit and passes the item on.
`default_nettype none
module cire_root_cell
  import cire_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire cell_t in_cell,
  output logic       out_valid,
  output cell_t      out_cell
);

  logic  valid_r;
  cell_t cell_r;
  cell_t cell_nxt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  always_comb begin
    cell_nxt = in_cell;
    rem_sh   = {in_cell.rem[REM_W-3:0], in_cell.rad[RAD_W-1 -: 2]};
    trial    = {in_cell.root, 2'b01};
    cell_nxt.rad = {in_cell.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      cell_nxt.rem  = rem_sh - trial;
      cell_nxt.root = {in_cell.root[ROOT_W-2:0], 1'b1};
    end else begin
      cell_nxt.rem  = rem_sh;
      cell_nxt.root = {in_cell.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_cell  = cell_r;

endmodule
`default_nettype wire

[hdl/cire_back.sv]
// Back stages: drift and diffusion products, scaling, sum and saturation.
`default_nettype none
module cire_back
  import cire_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire cell_t       in_cell,
  input  wire logic [31:0] vol,
  output logic             out_valid,
  output out_t             out_data
);

  logic v1_r, v2_r, v3_r;
  logic [63:0] dlo_r;
  logic [64:0] dhi_r;
  logic [63:0] vr_r;
  logic signed [32:0] base1_r, base2_r, base3_r;
  logic dneg1_r;
  logic [31:0] dwm1_r;
  logic dwn1_r, dwn2_r;
  logic signed [DRIFT_W-1:0] dterm2_r, dterm3_r;
  logic [63:0] elo_r, ehi_r;
  logic signed [DIFFU_W-1:0] eterm3_r;

  logic [DRIFT_MAG_W-1:0] dmag;
  logic signed [DRIFT_MAG_W:0] dsx;
  logic [DIFFU_MAG_W-1:0] emag;
  logic signed [DIFFU_MAG_W:0] esx;
  logic signed [SUM_W-1:0] sum;

  always_comb begin
    dmag = {dhi_r, 32'b0} + DRIFT_MAG_W'(dlo_r);
    dsx  = dneg1_r ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
    emag = {ehi_r, 32'b0} + DIFFU_MAG_W'(elo_r);
    esx  = dwn2_r ? -$signed({1'b0, emag}) : $signed({1'b0, emag});
    sum  = SUM_W'(base3_r) + SUM_W'(dterm3_r) + SUM_W'(eterm3_r);
    if (sum > SUM_W'(64'sh7FFFFFFF)) begin
      out_data.next_value = 32'sh7FFFFFFF;
      out_data.saturated  = 1'b1;
    end else if (sum < -SUM_W'(64'sh80000000)) begin
      out_data.next_value = 32'sh80000000;
      out_data.saturated  = 1'b1;
    end else begin
      out_data.next_value = sum[31:0];
      out_data.saturated  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dlo_r    <= in_cell.pa[31:0] * in_cell.dt;
      dhi_r    <= in_cell.pa[PA_W-1:32] * in_cell.dt;
      vr_r     <= in_cell.root * vol;
      base1_r  <= in_cell.base;
      dneg1_r  <= in_cell.diff_neg;
      dwm1_r   <= in_cell.dw_mag;
      dwn1_r   <= in_cell.dw_neg;
      dterm2_r <= DRIFT_W'(dsx >>> SHIFT);
      elo_r    <= vr_r[31:0] * dwm1_r;
      ehi_r    <= vr_r[63:32] * dwm1_r;
      base2_r  <= base1_r;
      dwn2_r   <= dwn1_r;
      eterm3_r <= DIFFU_W'(esx >>> SHIFT);
      dterm3_r <= dterm2_r;
      base3_r  <= base2_r;
    end
  end

  assign out_valid = v3_r;

endmodule
`default_nettype wire

[hdl/cir_euler_step.sv]
// Top level of the square-root mean-reverting process Euler step block.
// The input channel carries one transaction per step: current value, step
// length and a normal draw, all Q8.24. The result channel returns one
// transaction per input, in order: the next value, saturated to 32 bits,
// and a flag that is set when clipping occurred.
// Configuration registers (speed, mean, volatility, scheme) are written
// through the cfg channel, which is always ready; write them only while
// no transaction is in flight.
// Throughput is one transaction per cycle while in_stall is low. From
// acceptance to out_valid a transaction passes two front stages,
// 32 square-root cells that each settle one root bit, three product and
// scaling stages and the output register.
// Reset clears all valid bits and the configuration registers.
// When the receiver stalls, a second result is held in a skid register
// and the input keeps flowing until that register fills; in_stall then
// rises and the whole chain holds until the receiver takes a result.
`default_nettype none
module cir_euler_step
  import cire_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cfg_t  cfg_r;
  logic  adv;
  logic  valid_c [0:NUM_CELLS];
  cell_t cell_c  [0:NUM_CELLS];
  logic  emit_v;
  out_t  emit_d;
  logic  out_v_r, out_v_nxt;
  out_t  out_d_r, out_d_nxt;
  logic  skid_v_r, skid_v_nxt;
  out_t  skid_d_r, skid_d_nxt;
  logic  out_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SPEED:  cfg_r.speed  <= cfg_data;
        CFG_MEAN:   cfg_r.mean   <= cfg_data;
        CFG_VOL:    cfg_r.vol    <= cfg_data;
        CFG_SCHEME: cfg_r.scheme <= cfg_data[1:0];
        default:    cfg_r <= cfg_r;
      endcase
    end
  end

  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;

  cire_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .out_valid (valid_c[0]),
    .out_cell  (cell_c[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    cire_root_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (valid_c[i]),
      .in_cell   (cell_c[i]),
      .out_valid (valid_c[i+1]),
      .out_cell  (cell_c[i+1])
    );
  end

  cire_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (valid_c[NUM_CELLS]),
    .in_cell   (cell_c[NUM_CELLS]),
    .vol       (cfg_r.vol),
    .out_valid (emit_v),
    .out_data  (emit_d)
  );

  assign out_take = out_v_r && !out_stall;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (out_take) begin
      out_v_nxt = 1'b0;
    end
    if (out_take && skid_v_r) begin
      out_v_nxt  = 1'b1;
      out_d_nxt  = skid_d_r;
      skid_v_nxt = 1'b0;
    end else if (adv && emit_v) begin
      if (!out_v_r || out_take) begin
        out_v_nxt = 1'b1;
        out_d_nxt = emit_d;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = emit_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full while output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && skid_v_r) |=> (!skid_v_r && out_v_r))
    else $error("skid register did not drain into output register");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_d_r.saturated) |->
      (out_d_r.next_value == 32'sh7FFFFFFF || out_d_r.next_value == 32'sh80000000))
    else $error("saturated flag with an unclipped value");

  a_hold_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_take) |=> skid_v_r)
    else $error("skid register lost a result");

endmodule
`default_nettype wire

[bench/testbench.sv]
// Testbench for the Euler step block: a directed table and random steps against a predictor.
`default_nettype none
module testbench;
  import cire_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY  = 37;
  localparam int WD_LIMIT = 4000;
  localparam int N_RANDOM = 1950;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  cir_euler_step DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [31:0] speed_q, mean_q, vol_q;
  logic [1:0] scheme_q;
  out_t next_q[$];
  int errors;
  int idle_pct, stall_pct;
  int wd_count;
  bit timed_out;

  typedef struct {
    logic [31:0] cv, dt, dw;
    bit known;
    logic [31:0] nv;
    logic sat;
  } row_t;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic out_t euler_next(in_t it);
    logic signed [33:0] x, pos, ax, base, d, s, diff;
    logic signed [199:0] drift, diffu, sum;
    logic [63:0] root;
    out_t r;
    x = 34'(it.current_value);
    pos = (x > 0) ? x : 34'sd0;
    ax = (x < 0) ? -x : x;
    if (scheme_q[1]) begin
      base = ax; d = ax; s = ax;
    end else if (scheme_q == SCH_FULL) begin
      base = x; d = pos; s = pos;
    end else begin
      base = x; d = x; s = pos;
    end
    diff = $signed({2'b0, mean_q}) - d;
    drift = 200'(diff) * $signed({1'b0, speed_q}) * $signed({1'b0, it.time_step});
    drift = drift >>> SHIFT;
    root = int_sqrt(64'(s) * 64'(it.time_step));
    diffu = $signed({1'b0, vol_q}) * $signed({1'b0, root}) * 200'(it.normal_draw);
    diffu = diffu >>> SHIFT;
    sum = 200'(base) + drift + diffu;
    r.saturated = 1'b0;
    if (sum > 200'sd2147483647) begin
      r.next_value = 32'h7FFF_FFFF; r.saturated = 1'b1;
    end else if (sum < -200'sd2147483648) begin
      r.next_value = 32'h8000_0000; r.saturated = 1'b1;
    end else begin
      r.next_value = sum[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (in_valid && !in_stall || out_valid && !out_stall || cfg_valid && cfg_ready)
        wd_count <= 0;
      else
        wd_count <= wd_count + 1;
      if (out_valid && !out_stall) begin
        if (next_q.size() == 0) begin
          report_mismatch("unexpected result transaction", out_data.next_value, 32'h0);
        end else begin
          out_t e;
          e = next_q.pop_front();
          if (out_data.next_value !== e.next_value)
            report_mismatch("next_value", out_data.next_value, e.next_value);
          if (out_data.saturated !== e.saturated)
            report_mismatch("saturated", 32'(out_data.saturated), 32'(e.saturated));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (wd_count >= WD_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SPEED:  speed_q = val;
      CFG_MEAN:   mean_q = val;
      CFG_VOL:    vol_q = val;
      CFG_SCHEME: scheme_q = val[1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (next_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_all(logic [31:0] sp, logic [31:0] mn, logic [31:0] vl, logic [1:0] sc);
    drain();
    write_reg(CFG_SPEED, sp);
    write_reg(CFG_MEAN, mn);
    write_reg(CFG_VOL, vl);
    write_reg(CFG_SCHEME, sc);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_step(in_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    next_q.push_back(euler_next(it));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return $urandom_range(32'h0400_0000);
      3: return -$urandom_range(32'h0400_0000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    row_t rows[$];
    in_t it;
    int n;
    errors = 0; timed_out = 0; wd_count = 0;
    idle_pct = 0; stall_pct = 0;
    speed_q = 0; mean_q = 0; vol_q = 0; scheme_q = SCH_PARTIAL;
    rst_n = 0; in_valid = 0; in_data = '0; out_stall = 0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset all coefficients are zero, so the step returns the base.
    rows.push_back('{32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 1, 32'h0100_0000, 0});
    rows.push_back('{32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 32'h8000_0000, 0});
    rows.push_back('{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1, 32'h7FFF_FFFF, 0});
    foreach (rows[i]) begin
      it = '{rows[i].cv, rows[i].dt, rows[i].dw};
      if (rows[i].known) begin
        out_t e;
        e = euler_next(it);
        if (e.next_value !== rows[i].nv || e.saturated !== rows[i].sat)
          report_mismatch("table", e.next_value, rows[i].nv);
      end
      send_step(it);
    end
    in_valid <= 1'b0;

    for (int sc = 0; sc < 4; sc++) begin
      set_all(32'h0080_0000, 32'h0100_0000, 32'h0040_0000, sc[1:0]);
      foreach (rows[i]) send_step('{rows[i].cv, rows[i].dt, rows[i].dw});
      send_step('{32'h0000_0000, 32'h0000_0000, 32'h0100_0000});
      send_step('{32'hFF00_0000, 32'h0004_0000, 32'hFE00_0000});
      in_valid <= 1'b0;
    end
    set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SCH_REFLECT);
    foreach (rows[i]) send_step('{rows[i].cv, rows[i].dt, rows[i].dw});
    in_valid <= 1'b0;

    n = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 59; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 59; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      if (ph == 4)
        set_all(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, SCH_SPARE);
      else if ($urandom_range(3) == 0)
        set_all($urandom, $urandom, $urandom, 2'($urandom_range(3)));
      else
        set_all($urandom_range(32'h0400_0000), $urandom_range(32'h0400_0000),
                $urandom_range(32'h0200_0000), 2'($urandom_range(3)));
      repeat (N_RANDOM / 8) begin
        it.current_value = rand_value();
        it.time_step = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0100_0000);
        it.normal_draw = rand_value();
        send_step(it);
        n++;
        if (n == 100) begin
          in_valid <= 1'b0;
          while (next_q.size() != 0) @(posedge clk);
        end
      end
      in_valid <= 1'b0;
    end

    stall_pct = 0;
    drain();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
hdl/cire_pkg.sv
hdl/cire_front.sv
hdl/cire_root_cell.sv
hdl/cire_back.sv
hdl/cir_euler_step.sv
bench/testbench.sv
